// ===== src/fport_byte_destuff_deframer_assert.svh =====
// Assertion macros shared by the deframer modules
`ifndef FPORT_BYTE_DESTUFF_DEFRAMER_ASSERT_SVH
`define FPORT_BYTE_DESTUFF_DEFRAMER_ASSERT_SVH

// same-cycle implication, checked on the rising edge, masked during reset
`define FBD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FBD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/fbd_pkg.sv =====
// Types and constants for the byte destuffing deframer
package fbd_pkg;

   localparam logic [7:0] SOF_BYTE  = 8'h7e;
   localparam logic [7:0] MARK_BYTE = 8'h7d;
   localparam logic [7:0] XOR_BYTE  = 8'h20;
   localparam logic [7:0] LEN_LONG  = 8'h19;
   localparam logic [7:0] LEN_SHORT = 8'h08;

   // last index of a frame: length plus one
   localparam logic [4:0] LAST_IDX_LONG  = 5'd26;
   localparam logic [4:0] LAST_IDX_SHORT = 5'd9;

   localparam logic [1:0] EV_ABSORB  = 2'd0;
   localparam logic [1:0] EV_FRAME   = 2'd1;
   localparam logic [1:0] EV_DISCARD = 2'd2;

   localparam logic [1:0] FK_CONTROL   = 2'd0;
   localparam logic [1:0] FK_TELEMETRY = 2'd1;
   localparam logic [1:0] FK_UNKNOWN   = 2'd2;

   typedef enum logic [3:0] {
      ST_SEEK  = 4'b0001,
      ST_SOF   = 4'b0010,
      ST_SOF2  = 4'b0100,
      ST_FRAME = 4'b1000
   } sync_state_type;

   // destuffed beat handed from the input stage to the sync stage
   typedef struct packed {
      logic       mark;
      logic [7:0] data;
   } beat_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [7:0] data_byte;
      logic [4:0] byte_position;
      logic       frame_end;
      logic [1:0] frame_kind;
   } result_type;

endpackage

// ===== src/fport_byte_destuff_deframer.sv =====
// Top level: byte destuffing receive deframer
// Path: an accepted req beat passes the input register, then the result register, to its rsp beat.
// Throughput: one byte per cycle; the input register and result register
// each advance whenever the next stage can take a beat.
// Reset: synchronous, active high; clears escape mark, sync machine (seeking),
// frame counters and both valid flags. No clearing pass.
module fport_byte_destuff_deframer
   import fbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [12:8] byte_position, [15:13] zero
   output logic        rsp_tlast,   // frame_end
   output logic [3:0]  rsp_tuser    // [1:0] event_kind, [3:2] frame_kind
);

   logic       beat_valid;
   logic       beat_ready;
   beat_type   beat;
   result_type rsp;

   fbd_destuff u_destuff (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .beat_valid (beat_valid),
      .beat_ready (beat_ready),
      .beat       (beat)
   );

   fbd_sync u_sync (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat_ready (beat_ready),
      .beat       (beat),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {3'b000, rsp.byte_position, rsp.data_byte};
   assign rsp_tlast = rsp.frame_end;
   assign rsp_tuser = {rsp.frame_kind, rsp.event_kind};

endmodule

// ===== src/fbd_destuff.sv =====
// Input register with stuff-mark removal
module fbd_destuff
   import fbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   output logic       beat_valid,
   input  logic       beat_ready,
   output beat_type   beat
);

`include "fport_byte_destuff_deframer_assert.svh"

   logic     valid_ff, valid_in;
   logic     esc_ff, esc_in;
   beat_type beat_ff, beat_in;
   logic     accept;
   logic     is_mark;

   assign req_tready = !valid_ff || beat_ready;
   assign accept     = req_tvalid && req_tready;
   assign is_mark    = (req_tdata == MARK_BYTE);

   always_comb begin
      valid_in = accept || (valid_ff && !beat_ready);
      esc_in   = esc_ff;
      beat_in  = beat_ff;
      if (accept) begin
         esc_in       = is_mark;
         beat_in.mark = is_mark;
         beat_in.data = (esc_ff && !is_mark) ? (req_tdata ^ XOR_BYTE) : req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         esc_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         esc_ff   <= esc_in;
      end
      beat_ff <= beat_in;
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

   `FBD_ASSERT_NEXT(a_mark_sets_esc, accept && is_mark, esc_ff, "mark beat did not set escape")
   `FBD_ASSERT_NEXT(a_data_clears_esc, accept && !is_mark, !esc_ff,
                    "data beat left escape set")
   `FBD_ASSERT_NOW(a_mark_raw, valid_ff && beat_ff.mark, beat_ff.data == MARK_BYTE,
                   "mark beat carries wrong byte")

endmodule

// ===== src/fbd_sync.sv =====
// Sync state machine and result register
module fbd_sync
   import fbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       beat_valid,
   output logic       beat_ready,
   input  beat_type   beat,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

`include "fport_byte_destuff_deframer_assert.svh"

   sync_state_type state_ff, state_in;
   logic [4:0]     count_ff, count_in;
   logic           long_ff, long_in;
   logic [1:0]     type_ff, type_in;
   logic           valid_ff, valid_in;
   result_type     rsp_ff, rsp_in;
   result_type     res;
   logic           proc;
   logic [7:0]     x;
   logic [1:0]     cls;
   logic [1:0]     tk;
   logic           last;

   assign beat_ready = !valid_ff || rsp_ready;
   assign proc       = beat_valid && beat_ready;
   assign x          = beat.data;

   always_comb begin
      cls = FK_UNKNOWN;
      if (x == 8'h00) begin
         cls = FK_CONTROL;
      end else if (x == 8'h01) begin
         cls = FK_TELEMETRY;
      end
   end

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      long_in           = long_ff;
      type_in           = type_ff;
      res.event_kind    = EV_ABSORB;
      res.data_byte     = x;
      res.byte_position = 5'd0;
      res.frame_end     = 1'b0;
      res.frame_kind    = FK_CONTROL;
      tk                = (count_ff == 5'd1) ? cls : type_ff;
      last              = long_ff ? (count_ff >= LAST_IDX_LONG) : (count_ff >= LAST_IDX_SHORT);
      if (!beat.mark) begin
         unique case (state_ff)
            ST_SEEK: begin
               count_in = 5'd0;
               if (x == SOF_BYTE) begin
                  state_in = ST_SOF;
               end else begin
                  res.event_kind = EV_DISCARD;
               end
            end
            ST_SOF: begin
               count_in = 5'd0;
               if (x == SOF_BYTE) begin
                  state_in = ST_SOF2;
               end else if (x == LEN_LONG) begin
                  state_in       = ST_FRAME;
                  count_in       = 5'd1;
                  long_in        = 1'b1;
                  type_in        = FK_CONTROL;
                  res.event_kind = EV_FRAME;
               end else begin
                  state_in       = ST_SEEK;
                  res.event_kind = EV_DISCARD;
               end
            end
            ST_SOF2: begin
               if (x == LEN_LONG || x == LEN_SHORT) begin
                  state_in       = ST_FRAME;
                  count_in       = 5'd1;
                  long_in        = (x == LEN_LONG);
                  type_in        = FK_CONTROL;
                  res.event_kind = EV_FRAME;
               end else if (x != SOF_BYTE) begin
                  state_in       = ST_SEEK;
                  count_in       = 5'd0;
                  res.event_kind = EV_DISCARD;
               end
            end
            ST_FRAME: begin
               res.event_kind    = EV_FRAME;
               res.byte_position = count_ff;
               type_in           = tk;
               if (last) begin
                  res.frame_end  = 1'b1;
                  res.frame_kind = tk;
                  state_in       = ST_SEEK;
                  count_in       = 5'd0;
                  type_in        = FK_CONTROL;
               end else begin
                  count_in = count_ff + 5'd1;
               end
            end
            default: begin
               state_in = ST_SEEK;
               count_in = 5'd0;
            end
         endcase
      end
   end

   always_comb begin
      valid_in = proc || (valid_ff && !rsp_ready);
      rsp_in   = proc ? res : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SEEK;
         count_ff <= 5'd0;
         long_ff  <= 1'b0;
         type_ff  <= FK_CONTROL;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (proc) begin
            state_ff <= state_in;
            count_ff <= count_in;
            long_ff  <= long_in;
            type_ff  <= type_in;
         end
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   `FBD_ASSERT_NEXT(a_end_to_seek, proc && res.frame_end, state_ff == ST_SEEK,
                    "frame end did not return to seeking")
   `FBD_ASSERT_NOW(a_count_idle, state_ff != ST_FRAME, count_ff == 5'd0,
                   "byte count nonzero outside a frame")
   `FBD_ASSERT_NOW(a_end_is_frame, valid_ff && rsp_ff.frame_end,
                   rsp_ff.event_kind == EV_FRAME, "frame end on a non-frame beat")

endmodule

// ===== tb/deframer_result_check.sv =====
// Watches both streams, predicts each deframer event and compares it with the rsp beats
`timescale 1ns / 100ps

module deframer_result_check
   import fbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [7:0] data_byte, [12:8] byte_position, [15:13] zero
   input  logic        rsp_tlast,   // frame_end
   input  logic [3:0]  rsp_tuser,   // [1:0] event_kind, [3:2] frame_kind
   output int          mismatch_count,
   output int          events_pending
);

   result_type     expected_events[$];
   logic           mark_seen;
   sync_state_type hunt_state;
   logic [4:0]     frame_index;
   logic [7:0]     frame_len;
   logic [7:0]     type_byte;

   function automatic void begin_frame(input logic [7:0] len);
      frame_len   = len;
      type_byte   = 8'h00;
      frame_index = 5'd1;
      hunt_state  = ST_FRAME;
   endfunction

   // one line byte in, one event out; updates the predicted deframer state
   function automatic result_type deframe_byte(input logic [7:0] raw);
      result_type ev;
      logic [7:0] x;
      int         next_index;
      x  = raw;
      ev = '0;
      ev.event_kind = EV_ABSORB;
      if (x == MARK_BYTE) begin
         mark_seen = 1'b1;
      end else begin
         if (mark_seen) begin
            x = x ^ XOR_BYTE;
            mark_seen = 1'b0;
         end
         case (hunt_state)
            ST_SEEK: begin
               frame_index = 5'd0;
               if (x == SOF_BYTE) hunt_state = ST_SOF;
               else ev.event_kind = EV_DISCARD;
            end
            ST_SOF: begin
               frame_index = 5'd0;
               if (x == SOF_BYTE) begin
                  hunt_state = ST_SOF2;
               end else if (x == LEN_LONG) begin
                  begin_frame(x);
                  ev.event_kind = EV_FRAME;
               end else begin
                  hunt_state = ST_SEEK;
                  ev.event_kind = EV_DISCARD;
               end
            end
            ST_SOF2: begin
               if (x == LEN_LONG || x == LEN_SHORT) begin
                  begin_frame(x);
                  ev.event_kind = EV_FRAME;
               end else if (x != SOF_BYTE) begin
                  frame_index = 5'd0;
                  hunt_state = ST_SEEK;
                  ev.event_kind = EV_DISCARD;
               end
            end
            default: begin
               ev.event_kind    = EV_FRAME;
               ev.byte_position = frame_index;
               if (frame_index == 5'd1) type_byte = x;
               next_index = int'(frame_index) + 1;
               if (next_index >= int'(frame_len) + 2 || next_index > 31) begin
                  ev.frame_end  = 1'b1;
                  ev.frame_kind = (type_byte == 8'h00) ? FK_CONTROL :
                                  (type_byte == 8'h01) ? FK_TELEMETRY : FK_UNKNOWN;
                  frame_index = 5'd0;
                  frame_len   = 8'h00;
                  type_byte   = 8'h00;
                  hunt_state  = ST_SEEK;
               end else begin
                  frame_index = next_index[4:0];
               end
            end
         endcase
      end
      ev.data_byte = x;
      return ev;
   endfunction

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   initial begin
      mismatch_count = 0;
      events_pending = 0;
   end

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         mark_seen   = 1'b0;
         hunt_state  = ST_SEEK;
         frame_index = 5'd0;
         frame_len   = 8'h00;
         type_byte   = 8'h00;
         expected_events.delete();
      end else begin
         // compare first: a beat leaving now can never belong to the one entering now
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected rsp beat, expected none actual %h/%h/%h", $time,
                        rsp_tdata, rsp_tlast, rsp_tuser);
            end else begin
               want = expected_events.pop_front();
               compare_field("event_kind", 8'(want.event_kind), 8'(rsp_tuser[1:0]));
               compare_field("data_byte", want.data_byte, rsp_tdata[7:0]);
               compare_field("byte_position", 8'(want.byte_position), 8'(rsp_tdata[12:8]));
               compare_field("tdata padding", 8'h00, 8'(rsp_tdata[15:13]));
               compare_field("frame_end", 8'(want.frame_end), 8'(rsp_tlast));
               compare_field("frame_kind", 8'(want.frame_kind), 8'(rsp_tuser[3:2]));
            end
         end
         if (req_tvalid && req_tready) expected_events.push_back(deframe_byte(req_tdata));
      end
      events_pending = expected_events.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the deframer testbench: clock, reset, line byte stimulus and verdict
`timescale 1ns / 100ps

module testbench;
   import fbd_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [7:0] data_byte, [12:8] byte_position, [15:13] zero
   logic        rsp_tlast;    // frame_end
   logic [3:0]  rsp_tuser;    // [1:0] event_kind, [3:2] frame_kind
   int          mismatch_count;
   int          events_pending;
   int          bytes_sent;
   logic        req_gappy;

   always #1 clock = ~clock;

   fport_byte_destuff_deframer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   deframer_result_check monitor (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .events_pending (events_pending)
   );

   // called at a falling edge, returns at a falling edge once the beat is taken
   task automatic push_byte(input logic [7:0] b);
      int gap;
      if (bytes_sent % 64 == 0) req_gappy = $urandom_range(0, 3) != 0;
      gap = req_gappy ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      bytes_sent++;
   endtask

   // escape the byte where the line needs it, and now and then where it does not
   task automatic push_line_byte(input logic [7:0] b);
      logic escape;
      escape = (b == MARK_BYTE) || (b == SOF_BYTE && $urandom_range(0, 3) != 0) ||
               ($urandom_range(0, 15) == 0 && (b ^ XOR_BYTE) != MARK_BYTE);
      if (escape) begin
         push_byte(MARK_BYTE);
         push_byte(b ^ XOR_BYTE);
      end else begin
         push_byte(b);
      end
   endtask

   task automatic push_frame;
      int         starts;
      int         payload;
      logic [7:0] len;
      logic [7:0] frame_type;
      starts = $urandom_range(1, 3);
      repeat (starts) push_line_byte(SOF_BYTE);
      len = (starts == 1 || $urandom_range(0, 1) == 1) ? LEN_LONG : LEN_SHORT;
      push_line_byte(len);
      case ($urandom_range(0, 3))
         0: frame_type = 8'h00;
         1: frame_type = 8'h01;
         default: frame_type = 8'($urandom_range(0, 255));
      endcase
      push_line_byte(frame_type);
      // the odd frame is cut short so the next start lands inside it
      payload = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len;
      repeat (payload) push_line_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic push_noise;
      logic [7:0] b;
      repeat ($urandom_range(1, 8)) begin
         case ($urandom_range(0, 5))
            0: b = SOF_BYTE;
            1: b = MARK_BYTE;
            2: b = LEN_LONG;
            3: b = LEN_SHORT;
            default: b = 8'($urandom_range(0, 255));
         endcase
         push_byte(b);
      end
   endtask

   initial begin
      logic [7:0] directed[$];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      bytes_sent = 0;
      req_gappy  = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // extremes; mark after mark with a destuffed start; repeated starts; short
      // telemetry frame carrying raw and escaped starts and marks; bad lengths
      directed = '{8'h00, 8'hff, MARK_BYTE, MARK_BYTE, 8'h5e, SOF_BYTE, SOF_BYTE,
                   LEN_SHORT, 8'h01, SOF_BYTE, MARK_BYTE, 8'h5d, MARK_BYTE, 8'h5e,
                   8'h55, 8'haa, 8'h00, 8'hff, 8'h33,
                   SOF_BYTE, 8'h42, SOF_BYTE, SOF_BYTE, 8'h13};
      foreach (directed[i]) push_byte(directed[i]);

      while (bytes_sent < 1320) begin
         if ($urandom_range(0, 3) != 0) push_frame();
         else push_noise();
      end
      req_tvalid <= 1'b0;

      wait (events_pending == 0);
      repeat (6) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("fport_byte_destuff_deframer regression: pass");
      end else begin
         $display("fport_byte_destuff_deframer regression: fail");
      end
      $finish;
   end

   // result side back-pressure: a random hold before each beat, with calm stretches
   initial begin
      int hold;
      int beats;
      logic gappy;
      rsp_tready = 1'b0;
      beats = 0;
      gappy = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (beats % 48 == 0) gappy = $urandom_range(0, 3) != 0;
         hold = gappy ? $urandom_range(0, 16) : 0;
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
         beats++;
      end
   end

   initial begin
      #1000000;
      $display("fport_byte_destuff_deframer regression: fail");
      $finish;
   end

endmodule

// ===== fport_byte_destuff_deframer.f =====
+incdir+src
src/fbd_pkg.sv
src/fbd_destuff.sv
src/fbd_sync.sv
src/fport_byte_destuff_deframer.sv
tb/deframer_result_check.sv
tb/testbench.sv
